// ===== src/rsl_pkg.sv =====
// Shared constants and types for the radial spotlight luma block.
// No dependencies; every other file takes its names from here.
`timescale 1ns / 1ps

package rsl_pkg;

    // Default widths of the pixel word
    localparam int COORD_BITS_DEF    = 12;
    localparam int LUM_FRAC_BITS_DEF = 16;

    // Configuration port
    localparam int CENTER_BITS   = 14;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = CENTER_BITS;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_X = 1'b0,
        CFG_CENTER_Y = 1'b1
    } t_cfg_idx;

    // Falloff: factor is (FULL_SCALE - r) / FULL_SCALE with r clamped at R_MAX
    localparam int R_MAX      = 160;
    localparam int FULL_SCALE = 200;
    localparam int R_BITS     = 8;
    localparam int D2_BITS    = 16;
    localparam int FAR_D2     = (R_MAX + 1) * (R_MAX + 1);

    // Integer square root: one result bit per step
    localparam int ROOT_STEPS     = R_BITS;
    localparam int ROOT_PER_STAGE = ROOT_STEPS / 2;

    // Divide by FULL_SCALE as a shift by 3 then a divide by the odd part 25
    localparam int SCALE_SHIFT    = 3;
    localparam int SCALE_ODD      = FULL_SCALE >> SCALE_SHIFT;
    localparam int SCALE_ODD_LOG  = 5;

endpackage

// ===== src/rsl_pix_if.sv =====
// Pixel input channel: valid/ready handshake with coordinate and luma payload.
// Depends on rsl_pkg for default widths.
`timescale 1ns / 1ps

interface rsl_pix_if #(
    parameter int COORD_BITS = rsl_pkg::COORD_BITS_DEF,
    parameter int LUM_BITS   = rsl_pkg::LUM_FRAC_BITS_DEF + 1
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [LUM_BITS-1:0]   lum_in;

    modport source (output valid, pixel_x, pixel_y, lum_in, input ready);
    modport sink   (input valid, pixel_x, pixel_y, lum_in, output ready);
endinterface

// ===== src/rsl_lum_if.sv =====
// Luma output channel: valid/ready handshake with the dimmed luma payload.
// Depends on rsl_pkg for the default width.
`timescale 1ns / 1ps

interface rsl_lum_if #(
    parameter int LUM_BITS = rsl_pkg::LUM_FRAC_BITS_DEF + 1
);
    logic                valid;
    logic                ready;
    logic [LUM_BITS-1:0] lum_out;

    modport source (output valid, lum_out, input ready);
    modport sink   (input valid, lum_out, output ready);
endinterface

// ===== src/rsl_dist.sv =====
// Distance front end: two stages, |dx| and |dy| with far detect, then dx^2 + dy^2.
// Depends on rsl_pkg.
`timescale 1ns / 1ps

module rsl_dist #(
    parameter int COORD_BITS = rsl_pkg::COORD_BITS_DEF,
    parameter int LUM_BITS   = rsl_pkg::LUM_FRAC_BITS_DEF + 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [COORD_BITS-1:0]            i_pixel_x,
    input  logic [COORD_BITS-1:0]            i_pixel_y,
    input  logic [LUM_BITS-1:0]              i_lum,
    input  logic [rsl_pkg::CENTER_BITS-1:0]  i_center_x,
    input  logic [rsl_pkg::CENTER_BITS-1:0]  i_center_y,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [rsl_pkg::D2_BITS-1:0]      o_d2,
    output logic                             o_far,
    output logic [LUM_BITS-1:0]              o_lum
);
    localparam int CB = rsl_pkg::CENTER_BITS;
    localparam int DW = ((COORD_BITS > CB) ? COORD_BITS : CB) + 2;
    localparam int RB = rsl_pkg::R_BITS;
    localparam int QB = rsl_pkg::D2_BITS;

    logic                    r_v1, r_v2;
    logic [RB-1:0]           r_dx, r_dy;
    logic                    r_far1, r_far2;
    logic [LUM_BITS-1:0]     r_lum1, r_lum2;
    logic [QB-1:0]           r_d2;

    logic                    w_rdy1, w_rdy2;
    logic signed [DW-1:0]    w_px, w_py, w_cx, w_cy, w_sx, w_sy;
    logic [DW-1:0]           w_ax, w_ay;
    logic                    w_far1, w_far2;
    logic [QB-1:0]           w_d2;

    // Stage advance: a stage loads when empty or when its word moves on
    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Stage 1: exact signed differences and their magnitudes
    always_comb begin
        w_px = $signed({{(DW-COORD_BITS){1'b0}}, i_pixel_x});
        w_py = $signed({{(DW-COORD_BITS){1'b0}}, i_pixel_y});
        w_cx = $signed({{(DW-CB){i_center_x[CB-1]}}, i_center_x});
        w_cy = $signed({{(DW-CB){i_center_y[CB-1]}}, i_center_y});
        w_sx = w_px - w_cx;
        w_sy = w_py - w_cy;
        w_ax = w_sx[DW-1] ? $unsigned(-w_sx) : $unsigned(w_sx);
        w_ay = w_sy[DW-1] ? $unsigned(-w_sy) : $unsigned(w_sy);
        // either leg past the clamp radius puts the pixel on the floor
        w_far1 = (w_ax > DW'(rsl_pkg::R_MAX)) || (w_ay > DW'(rsl_pkg::R_MAX));
    end

    // Stage 2: squared distance of the legs truncated to R_BITS bits
    always_comb begin
        w_d2   = QB'(QB'(r_dx) * QB'(r_dx) + QB'(r_dy) * QB'(r_dy));
        w_far2 = r_far1 || (w_d2 >= QB'(rsl_pkg::FAR_D2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_dx   <= w_ax[RB-1:0];
            r_dy   <= w_ay[RB-1:0];
            r_far1 <= w_far1;
            r_lum1 <= i_lum;
        end
        if (w_rdy2) begin
            r_d2   <= w_d2;
            r_far2 <= w_far2;
            r_lum2 <= r_lum1;
        end
    end

    assign o_valid = r_v2;
    assign o_d2    = r_d2;
    assign o_far   = r_far2;
    assign o_lum   = r_lum2;

endmodule

// ===== src/rsl_root.sv =====
// One stage of the integer square root: STEPS digit-by-digit steps, registered.
// Depends on rsl_pkg; two of these in series give the full 8-bit root.
`timescale 1ns / 1ps

module rsl_root #(
    parameter int LUM_BITS   = rsl_pkg::LUM_FRAC_BITS_DEF + 1,
    parameter int FIRST_STEP = 0,
    parameter int STEPS      = rsl_pkg::ROOT_PER_STAGE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rsl_pkg::D2_BITS-1:0]  i_op,
    input  logic [rsl_pkg::D2_BITS-1:0]  i_res,
    input  logic                         i_far,
    input  logic [LUM_BITS-1:0]          i_lum,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rsl_pkg::D2_BITS-1:0]  o_op,
    output logic [rsl_pkg::D2_BITS-1:0]  o_res,
    output logic                         o_far,
    output logic [LUM_BITS-1:0]          o_lum
);
    localparam int QB = rsl_pkg::D2_BITS;

    logic                r_v;
    logic [QB-1:0]       r_op, r_res;
    logic                r_far;
    logic [LUM_BITS-1:0] r_lum;

    logic                w_rdy;
    logic [QB-1:0]       w_op, w_res, w_one;
    logic [QB:0]         w_t;

    assign w_rdy   = !r_v || i_ready;
    assign o_ready = w_rdy;

    // Remainder/root recurrence: one root bit per step, test bit moves down two places per step
    always_comb begin
        w_op  = i_op;
        w_res = i_res;
        w_one = '0;
        w_t   = '0;
        for (int k = 0; k < STEPS; k++) begin
            w_one = QB'(1) << (QB - 2 - 2 * (FIRST_STEP + k));
            w_t   = {1'b0, w_res} + {1'b0, w_one};
            if ({1'b0, w_op} >= w_t) begin
                w_op  = w_op - w_t[QB-1:0];
                w_res = (w_res >> 1) + w_one;
            end else begin
                w_res = w_res >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy) begin
            r_op  <= w_op;
            r_res <= w_res;
            r_far <= i_far;
            r_lum <= i_lum;
        end
    end

    assign o_valid = r_v;
    assign o_op    = r_op;
    assign o_res   = r_res;
    assign o_far   = r_far;
    assign o_lum   = r_lum;

endmodule

// ===== src/rsl_scale.sv =====
// Luma scaling: lum * (200 - r), then exact floor divide by 200 via reciprocal.
// Depends on rsl_pkg. Two register stages; the second one is the output register.
`timescale 1ns / 1ps

module rsl_scale #(
    parameter int LUM_BITS = rsl_pkg::LUM_FRAC_BITS_DEF + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rsl_pkg::R_BITS-1:0]  i_root,
    input  logic                        i_far,
    input  logic [LUM_BITS-1:0]         i_lum,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [LUM_BITS-1:0]         o_lum
);
    localparam int RB  = rsl_pkg::R_BITS;
    localparam int PW  = LUM_BITS + RB;
    localparam int N   = PW - rsl_pkg::SCALE_SHIFT;
    localparam int SH  = N + rsl_pkg::SCALE_ODD_LOG;
    localparam int QW  = 2 * N + 1;
    // ceil(2^SH / 25): exact floor quotient for every N-bit dividend
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + rsl_pkg::SCALE_ODD - 1) / rsl_pkg::SCALE_ODD;

    logic            r_v1, r_v2;
    logic [PW-1:0]   r_prod;
    logic [QW-1:0]   r_q;

    logic            w_rdy1, w_rdy2;
    logic [RB-1:0]   w_r, w_factor;
    logic [N-1:0]    w_y;
    logic [N:0]      w_recip;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Stage 1: clamp radius and form the falloff factor, 40..200
    always_comb begin
        w_r      = i_far ? RB'(rsl_pkg::R_MAX) : i_root;
        w_factor = RB'(rsl_pkg::FULL_SCALE) - w_r;
    end

    // Stage 2: drop the power-of-two part, multiply by the reciprocal of 25
    assign w_y     = r_prod[PW-1:rsl_pkg::SCALE_SHIFT];
    assign w_recip = (N + 1)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) r_prod <= PW'(i_lum) * PW'(w_factor);
        if (w_rdy2) r_q    <= QW'(w_y) * QW'(w_recip);
    end

    assign o_valid = r_v2;
    assign o_lum   = r_q[SH +: LUM_BITS];

endmodule

// ===== src/radial_spotlight_luma.sv =====
// Radial spotlight (vignette) on a luma pixel stream: top level.
// Depends on rsl_pkg, rsl_pix_if, rsl_lum_if, rsl_dist, rsl_root and rsl_scale.
`timescale 1ns / 1ps

// Each pixel word (x, y, lum) comes out as floor(lum * (200 - r) / 200), where
// r is the integer square root of the squared distance from the configured
// center, clamped at 160. The pipeline takes one word per clock while the
// output is not stalled, and has six register stages: two for the distance
// (leg magnitudes, then squares and sum), two for the square root (four root
// bits each), and two for scaling (factor multiply, then a reciprocal multiply
// that divides by 200). Stages move independently, so empty stages fill while
// the output waits. The center registers are written through the plain write
// port and take effect on words accepted after the write.

module radial_spotlight_luma #(
    parameter int COORD_BITS    = rsl_pkg::COORD_BITS_DEF,
    parameter int LUM_FRAC_BITS = rsl_pkg::LUM_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    rsl_pix_if.sink                             i_pix,
    rsl_lum_if.source                           o_lum,
    input  logic                                i_cfg_we,
    input  logic [rsl_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [rsl_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    localparam int LUM_BITS = LUM_FRAC_BITS + 1;
    localparam int CB       = rsl_pkg::CENTER_BITS;
    localparam int QB       = rsl_pkg::D2_BITS;
    localparam int RB       = rsl_pkg::R_BITS;

    logic [CB-1:0]       r_center_x, r_center_y;

    // distance -> root stage A
    logic                w_d_valid, w_d_ready, w_d_far;
    logic [QB-1:0]       w_d_d2;
    logic [LUM_BITS-1:0] w_d_lum;
    // root stage A -> root stage B
    logic                w_r1_valid, w_r1_ready, w_r1_far;
    logic [QB-1:0]       w_r1_op, w_r1_res;
    logic [LUM_BITS-1:0] w_r1_lum;
    // root stage B -> scale
    logic                w_r2_valid, w_r2_ready, w_r2_far;
    logic [QB-1:0]       w_r2_op, w_r2_res;
    logic [LUM_BITS-1:0] w_r2_lum;

    // Center registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (i_cfg_we) begin
            case (rsl_pkg::t_cfg_idx'(i_cfg_idx))
                rsl_pkg::CFG_CENTER_X: r_center_x <= i_cfg_data[CB-1:0];
                rsl_pkg::CFG_CENTER_Y: r_center_y <= i_cfg_data[CB-1:0];
                default: ;
            endcase
        end
    end

    rsl_dist #(
        .COORD_BITS (COORD_BITS),
        .LUM_BITS   (LUM_BITS)
    ) u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_pix.valid),
        .o_ready    (i_pix.ready),
        .i_pixel_x  (i_pix.pixel_x),
        .i_pixel_y  (i_pix.pixel_y),
        .i_lum      (i_pix.lum_in),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .o_valid    (w_d_valid),
        .i_ready    (w_d_ready),
        .o_d2       (w_d_d2),
        .o_far      (w_d_far),
        .o_lum      (w_d_lum)
    );

    // High root bits
    rsl_root #(
        .LUM_BITS   (LUM_BITS),
        .FIRST_STEP (0),
        .STEPS      (rsl_pkg::ROOT_PER_STAGE)
    ) u_root_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .o_ready (w_d_ready),
        .i_op    (w_d_d2),
        .i_res   ('0),
        .i_far   (w_d_far),
        .i_lum   (w_d_lum),
        .o_valid (w_r1_valid),
        .i_ready (w_r1_ready),
        .o_op    (w_r1_op),
        .o_res   (w_r1_res),
        .o_far   (w_r1_far),
        .o_lum   (w_r1_lum)
    );

    // Low root bits
    rsl_root #(
        .LUM_BITS   (LUM_BITS),
        .FIRST_STEP (rsl_pkg::ROOT_PER_STAGE),
        .STEPS      (rsl_pkg::ROOT_STEPS - rsl_pkg::ROOT_PER_STAGE)
    ) u_root_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_r1_valid),
        .o_ready (w_r1_ready),
        .i_op    (w_r1_op),
        .i_res   (w_r1_res),
        .i_far   (w_r1_far),
        .i_lum   (w_r1_lum),
        .o_valid (w_r2_valid),
        .i_ready (w_r2_ready),
        .o_op    (w_r2_op),
        .o_res   (w_r2_res),
        .o_far   (w_r2_far),
        .o_lum   (w_r2_lum)
    );

    rsl_scale #(
        .LUM_BITS (LUM_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_r2_valid),
        .o_ready (w_r2_ready),
        .i_root  (w_r2_res[RB-1:0]),
        .i_far   (w_r2_far),
        .i_lum   (w_r2_lum),
        .o_valid (o_lum.valid),
        .i_ready (o_lum.ready),
        .o_lum   (o_lum.lum_out)
    );

    // Near pixels carry a squared distance inside the clamp circle
    a_near_d2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_d_valid && !w_d_far) |-> (w_d_d2 < QB'(rsl_pkg::FAR_D2)))
        else $error("near pixel with squared distance past the clamp");

    // Finished root never exceeds the clamp radius for near pixels
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_r2_valid && !w_r2_far) |-> (w_r2_res <= QB'(rsl_pkg::R_MAX)))
        else $error("square root above clamp radius");

    // Root remainder bound: d2 - r^2 <= 2r
    a_root_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_r2_valid && !w_r2_far) |-> ({1'b0, w_r2_op} <= {w_r2_res, 1'b0}))
        else $error("square root remainder too large");

    // A word held at the distance output while the root stage is full stays put
    a_dist_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_d_valid && !w_d_ready) |=> (w_d_valid && $stable(w_d_d2) && $stable(w_d_lum)))
        else $error("distance word changed while stalled");

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for radial_spotlight_luma: directed edge words, then
// random pixel bursts under several center settings with a luma predictor.
// Depends on rsl_pkg, rsl_pix_if, rsl_lum_if and the radial_spotlight_luma top.
`timescale 1ns / 1ps

module testbench;

    localparam int XY_W       = rsl_pkg::COORD_BITS_DEF;
    localparam int LUM_FRAC   = rsl_pkg::LUM_FRAC_BITS_DEF;
    localparam int LUM_W      = LUM_FRAC + 1;
    localparam int CYCLE_CAP  = 200000;
    localparam int DRAIN_WAIT = 12;
    localparam int HOLD_LEN   = 80;
    localparam int HOLD_AT    = 170;
    localparam int PHASE_LEN  = 60;

    localparam logic [LUM_W-1:0] LUM_ONE = LUM_W'(1) << LUM_FRAC;

    typedef logic signed [rsl_pkg::CENTER_BITS-1:0] t_center;

    // Predicts the dimmed luma of each accepted pixel word and checks results in order
    class spotlight_scoreboard;
        t_center           center_x;
        t_center           center_y;
        logic [LUM_W-1:0]  expected_luma[$];
        int                checked;
        int                errors;

        function new();
            center_x = '0;
            center_y = '0;
            checked  = 0;
            errors   = 0;
        endfunction

        function void set_center(rsl_pkg::t_cfg_idx idx, t_center value);
            case (idx)
                rsl_pkg::CFG_CENTER_X: center_x = value;
                rsl_pkg::CFG_CENTER_Y: center_y = value;
                default: ;
            endcase
        endfunction

        // floor(lum * (200 - r) / 200), r = isqrt(dx^2 + dy^2) clamped at 160
        function logic [LUM_W-1:0] dimmed_luma(logic [XY_W-1:0] px, logic [XY_W-1:0] py,
                                               logic [LUM_W-1:0] lum);
            longint dx;
            longint dy;
            longint d2;
            longint scaled;
            longint trial;
            int     root;
            int     step_bit;
            dx = longint'(px) - longint'(center_x);
            dy = longint'(py) - longint'(center_y);
            d2 = dx * dx + dy * dy;
            root = 0;
            if (d2 >= rsl_pkg::FAR_D2) begin
                root = rsl_pkg::R_MAX;
            end else begin
                for (step_bit = 128; step_bit != 0; step_bit = step_bit >> 1) begin
                    trial = root | step_bit;
                    if (trial * trial <= d2) root = int'(trial);
                end
            end
            scaled = longint'(lum) * (rsl_pkg::FULL_SCALE - root) / rsl_pkg::FULL_SCALE;
            return scaled[LUM_W-1:0];
        endfunction

        function void note_pixel(logic [XY_W-1:0] px, logic [XY_W-1:0] py,
                                 logic [LUM_W-1:0] lum);
            expected_luma.push_back(dimmed_luma(px, py, lum));
        endfunction

        function void check_luma(logic [LUM_W-1:0] actual);
            logic [LUM_W-1:0] want;
            if (expected_luma.size() == 0) begin
                $error("lum_out word with no pixel pending: actual %0d", actual);
                errors++;
            end else begin
                want = expected_luma.pop_front();
                checked++;
                if (actual !== want) begin
                    $error("lum_out mismatch: expected %0d, actual %0d", want, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_luma.size();
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [rsl_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx;
    logic [rsl_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;

    rsl_pix_if pix ();
    rsl_lum_if lum ();

    radial_spotlight_luma u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix),
        .o_lum      (lum),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    spotlight_scoreboard sb = new();

    int cycles;
    int words_sent;
    int settings_used;
    bit hold_on;
    bit hold_done;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Cycle limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_CAP) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("radial_spotlight_luma verification failed");
        $finish;
    end

    // Output ready: rotating stall pattern, plus one long hold-off
    initial begin
        int rx_cycle;
        int hold_left;
        rx_cycle  = 0;
        hold_left = 0;
        hold_on   = 1'b0;
        hold_done = 1'b0;
        lum.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (hold_left > 0) begin
                lum.ready = 1'b0;
                hold_left--;
                if (hold_left == 0) hold_on = 1'b0;
            end else if (!hold_done && sb.checked >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_on   = 1'b1;
                hold_left = HOLD_LEN;
                lum.ready = 1'b0;
            end else begin
                case ((rx_cycle / 50) % 4)
                    0: lum.ready = 1'b1;
                    1: lum.ready = 1'($urandom_range(0, 1));
                    2: lum.ready = (rx_cycle % 4 == 0);
                    default: lum.ready = ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Result monitor
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && lum.valid && lum.ready) sb.check_luma(lum.lum_out);
        end
    end

    task automatic send_pixel(input logic [XY_W-1:0] px, input logic [XY_W-1:0] py,
                              input logic [LUM_W-1:0] l);
        @(negedge i_clk);
        pix.valid   = 1'b1;
        pix.pixel_x = px;
        pix.pixel_y = py;
        pix.lum_in  = l;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        sb.note_pixel(px, py, l);
        words_sent++;
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            pix.valid = 1'b0;
        end
    endtask

    // Stop offering until every pending word has come back
    task automatic wait_drained();
        @(negedge i_clk);
        pix.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_center(input rsl_pkg::t_cfg_idx idx, input t_center value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.set_center(idx, value);
    endtask

    // Coordinate usually near the center when the center is within reach, else anywhere
    function automatic logic [XY_W-1:0] pick_coord(t_center c);
        int v;
        if (int'(c) >= -170 && int'(c) <= 4265 && $urandom_range(0, 4) != 0) begin
            v = int'(c) + int'($urandom_range(0, 340)) - 170;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            return v[XY_W-1:0];
        end
        return XY_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [LUM_W-1:0] pick_luma();
        case ($urandom_range(0, 9))
            0: return LUM_W'($urandom_range(0, (1 << LUM_W) - 1));
            1: return LUM_ONE;
            2: return '0;
            3: return '1;
            default: return LUM_W'($urandom_range(0, 1 << LUM_FRAC));
        endcase
    endfunction

    // Random bursts; gaps optional so some phases run back to back
    task automatic random_phase(input int n, input bit with_gaps, input bit mid_drain);
        int left;
        int burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && left > 0) begin
                send_pixel(pick_coord(sb.center_x), pick_coord(sb.center_y), pick_luma());
                burst--;
                left--;
                if (mid_drain && left == n / 2) wait_drained();
            end
            if (with_gaps && !hold_on && $urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 6));
        end
    endtask

    task automatic directed_words();
        send_pixel(0, 0, 0);
        send_pixel(0, 0, LUM_ONE);
        send_pixel(0, 0, '1);
        send_pixel(0, 0, 1);
        send_pixel(3, 4, 65535);
        send_pixel(159, 0, LUM_ONE);
        send_pixel(160, 0, LUM_ONE);
        send_pixel(161, 0, LUM_ONE);
        send_pixel(0, 161, '1);
        send_pixel(113, 113, 99999);
        send_pixel(114, 113, 99999);
        send_pixel(114, 114, 99999);
        send_pixel('1, '1, '1);
        send_pixel('1, 0, 12345);
        send_pixel(0, '1, 54321);
        send_pixel(XY_W'(1) << (XY_W - 1), XY_W'(1) << (XY_W - 1),
                   LUM_W'(1) << (LUM_W - 1));
        send_pixel(12'h555, 12'haaa, 17'h15555);
        send_pixel(12'haaa, 12'h555, 17'h0aaaa);
        send_pixel(1, 1, 200);
        send_pixel(100, 50, 199);
    endtask

    task automatic run_setting(input t_center cx, input t_center cy, input bit with_gaps,
                               input bit mid_drain);
        wait_drained();
        write_center(rsl_pkg::CFG_CENTER_X, cx);
        write_center(rsl_pkg::CFG_CENTER_Y, cy);
        settings_used++;
        random_phase(PHASE_LEN, with_gaps, mid_drain);
    endtask

    // Main sequence
    initial begin
        t_center rx;
        t_center ry;
        words_sent    = 0;
        settings_used = 1;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = rsl_pkg::CFG_CENTER_X;
        i_cfg_data  = '0;
        pix.valid   = 1'b0;
        pix.pixel_x = '0;
        pix.pixel_y = '0;
        pix.lum_in  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset center (0, 0): edge words
        directed_words();

        run_setting(100, 100, 1'b1, 1'b0);
        run_setting(-8192, -8192, 1'b0, 1'b1);
        run_setting(2047, 1500, 1'b1, 1'b0);
        run_setting(8191, 8191, 1'b1, 1'b0);
        run_setting(4095, 4095, 1'b0, 1'b0);
        run_setting(-100, 4200, 1'b1, 1'b0);
        repeat (3) begin
            if ($urandom_range(0, 1)) begin
                rx = t_center'($urandom_range(0, 4095));
                ry = t_center'($urandom_range(0, 4095));
            end else begin
                rx = t_center'($urandom_range(0, (1 << rsl_pkg::CENTER_BITS) - 1));
                ry = t_center'($urandom_range(0, (1 << rsl_pkg::CENTER_BITS) - 1));
            end
            run_setting(rx, ry, 1'b1, 1'b0);
        end

        wait_drained();
        $display("Checked %0d of %0d pixel words across %0d center settings, %0d errors.",
                 sb.checked, words_sent, settings_used, sb.errors);
        $display("Included far, clamped and over-unity luma words plus a long output stall.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("radial_spotlight_luma verification clean");
        end else begin
            $display("radial_spotlight_luma verification failed");
        end
        $finish;
    end

endmodule

// ===== radial_spotlight_luma.f =====
src/rsl_pkg.sv
src/rsl_pix_if.sv
src/rsl_lum_if.sv
src/rsl_dist.sv
src/rsl_root.sv
src/rsl_scale.sv
src/radial_spotlight_luma.sv
tb/testbench.sv
